// ===== rtl/rlt_pkg.sv =====
// ----------------------------------------------------------------------------
// rlt_pkg: shared constants of the run-length line table
// Field widths, default capacity and result status codes.
// ----------------------------------------------------------------------------
package rlt_pkg;

  localparam int unsigned CAPACITY_DEF = 4096;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LINE_W = 16;
  localparam int unsigned COL_W  = 16;
  localparam int unsigned POS_W  = 12;
  localparam int unsigned STAT_W = 2;

  localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 2'd2;

endpackage

// ===== rtl/run_length_line_table_unit.sv =====
// ----------------------------------------------------------------------------
// run_length_line_table_unit: code store with run-length encoded line table
// Appends code bytes with line and column, answers position lookups by
// binary search over the start offsets of the line runs.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive mode_i and the payload, raise start_i; the request
//   is taken at the edge where start_i is high and busy_o is low.
//   mode_i = 0 appends code_byte_i / column_number_i at the next position;
//   line_number_i extends the last run or opens a new one. mode_i = 1 looks
//   up position_i.
//   Result channel: result_valid_o is high for exactly one cycle with
//   status_o, found_line_o and found_column_o; the receiver cannot stall, so
//   every result must be taken in that cycle.
// Throughput and sequencing:
//   Append and a lookup that misses: result in the cycle after the request,
//   busy_o stays low, so one request per cycle is sustained.
//   Lookup that hits: busy_o is high during the search, so no new request
//   is taken until it ends. Each binary-search probe is a registered read of
//   the run-start RAM, then the shared compare; after the last probe the
//   line and column are fetched and the result is registered.
// Reset:
//   Clears byte and run counts and the sequencer; RAM contents are left
//   undefined and are never read before being written.
// ----------------------------------------------------------------------------
module run_length_line_table_unit
  import rlt_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              mode_i,
  input  logic [BYTE_W-1:0] code_byte_i,
  input  logic [LINE_W-1:0] line_number_i,
  input  logic [COL_W-1:0]  column_number_i,
  input  logic [POS_W-1:0]  position_i,
  output logic              result_valid_o,
  output logic [STAT_W-1:0] status_o,
  output logic [LINE_W-1:0] found_line_o,
  output logic [COL_W-1:0]  found_column_o
);

  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned PW     = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PROBE = 5'b00010,
    ST_CMP   = 5'b00100,
    ST_FETCH = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]  byte_count_q, byte_count_d;
  logic [CNT_W-1:0]  run_count_q, run_count_d;
  logic [LINE_W-1:0] last_line_q, last_line_d;
  logic [CNT_W-1:0]  lo_q, lo_d;
  logic [CNT_W-1:0]  hi_q, hi_d;
  logic [CNT_W-1:0]  mid_q, mid_d;
  logic [PW-1:0]     pos_q, pos_d;

  logic              valid_q, valid_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic [COL_W-1:0]  col_q, col_d;

  // Request decode
  logic accept, do_append, do_lookup, store_full, new_run, pos_hit;
  logic [PW-1:0] pos_ext;

  assign accept     = start_i && (state_q == ST_IDLE);
  assign do_append  = accept && !mode_i;
  assign do_lookup  = accept && mode_i;
  assign store_full = (byte_count_q == CNT_W'(CAPACITY));
  assign new_run    = (run_count_q == '0) || (last_line_q != line_number_i);
  assign pos_ext    = PW'(position_i);
  assign pos_hit    = pos_ext < PW'(byte_count_q);

  // Shared search unit: interval width, midpoint and start compare
  logic [CNT_W-1:0]  span, mid;
  logic              narrowed, start_le_pos;
  logic [ADDR_W-1:0] start_rdata;
  logic [LINE_W-1:0] line_rdata;
  logic [COL_W-1:0]  col_rdata;

  assign span         = hi_q - lo_q;
  assign narrowed     = (span <= CNT_W'(1));
  assign mid          = lo_q + (span >> 1);
  assign start_le_pos = PW'(start_rdata) <= pos_q;

  // RAM ports
  logic              col_we, run_we;
  logic [ADDR_W-1:0] start_raddr, line_raddr, col_raddr;

  assign col_we      = do_append && !store_full;
  assign run_we      = col_we && new_run;
  assign start_raddr = mid[ADDR_W-1:0];
  assign line_raddr  = lo_q[ADDR_W-1:0];
  assign col_raddr   = pos_q[ADDR_W-1:0];

  rlt_ram #(.WIDTH(BYTE_W), .DEPTH(CAPACITY)) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (byte_count_q[ADDR_W-1:0]),
    .wdata_i (code_byte_i),
    .raddr_i (col_raddr),
    .rdata_o ()
  );

  rlt_ram #(.WIDTH(COL_W), .DEPTH(CAPACITY)) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (byte_count_q[ADDR_W-1:0]),
    .wdata_i (column_number_i),
    .raddr_i (col_raddr),
    .rdata_o (col_rdata)
  );

  rlt_ram #(.WIDTH(LINE_W), .DEPTH(CAPACITY)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (run_we),
    .waddr_i (run_count_q[ADDR_W-1:0]),
    .wdata_i (line_number_i),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  // Start offset of each run, written once when the run opens
  rlt_ram #(.WIDTH(ADDR_W), .DEPTH(CAPACITY)) u_start_ram (
    .clk_i   (clk_i),
    .we_i    (run_we),
    .waddr_i (run_count_q[ADDR_W-1:0]),
    .wdata_i (byte_count_q[ADDR_W-1:0]),
    .raddr_i (start_raddr),
    .rdata_o (start_rdata)
  );

  // Sequencer
  always_comb begin
    state_d      = state_q;
    byte_count_d = byte_count_q;
    run_count_d  = run_count_q;
    last_line_d  = last_line_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    pos_d        = pos_q;
    valid_d      = 1'b0;
    status_d     = status_q;
    line_d       = line_q;
    col_d        = col_q;

    unique case (state_q)
      ST_IDLE: begin
        if (do_append) begin
          valid_d  = 1'b1;
          line_d   = '0;
          col_d    = '0;
          status_d = store_full ? STATUS_FULL : STATUS_OK;
          if (!store_full) begin
            byte_count_d = byte_count_q + CNT_W'(1);
            if (new_run) begin
              run_count_d = run_count_q + CNT_W'(1);
              last_line_d = line_number_i;
            end
          end
        end else if (do_lookup) begin
          if (pos_hit) begin
            // Search [lo, hi) for the last run whose start is at or below pos
            lo_d    = '0;
            hi_d    = run_count_q;
            pos_d   = pos_ext;
            state_d = ST_PROBE;
          end else begin
            valid_d  = 1'b1;
            status_d = STATUS_NOT_FOUND;
            line_d   = '0;
            col_d    = '0;
          end
        end
      end
      ST_PROBE: begin
        if (narrowed) begin
          state_d = ST_FETCH;
        end else begin
          mid_d   = mid;
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (start_le_pos) begin
          lo_d = mid_q;
        end else begin
          hi_d = mid_q;
        end
        state_d = ST_PROBE;
      end
      ST_FETCH: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        valid_d  = 1'b1;
        status_d = STATUS_OK;
        line_d   = line_rdata;
        col_d    = col_rdata;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      byte_count_q <= '0;
      run_count_q  <= '0;
      valid_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      byte_count_q <= byte_count_d;
      run_count_q  <= run_count_d;
      valid_q      <= valid_d;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk_i) begin
    last_line_q <= last_line_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    pos_q       <= pos_d;
    status_q    <= status_d;
    line_q      <= line_d;
    col_q       <= col_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign found_line_o   = line_q;
  assign found_column_o = col_q;

  // Assertions
  a_runs_le_bytes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_count_q <= byte_count_q)
    else $error("run count exceeds byte count");

  a_search_interval : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE || state_q == ST_CMP) |-> (lo_q < hi_q && hi_q <= run_count_q))
    else $error("search interval empty or out of range");

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && status_q != STATUS_OK) |-> (line_q == '0 && col_q == '0))
    else $error("failed request returned nonzero fields");

  a_search_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |=> (valid_q && status_q == STATUS_OK && !busy_o))
    else $error("search did not deliver a result");

endmodule

// ===== rtl/rlt_ram.sv =====
// ----------------------------------------------------------------------------
// rlt_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rlt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/sv/run_length_line_table_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_length_line_table_unit_tb: self-checking bench for the line table
// Appends code bytes in line runs of random length and looks up positions
// in, at the edge of and past the stored range, up to and beyond a full
// store. A shadow line table predicts every result. A monitor compares each
// result strobe, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module run_length_line_table_unit_tb;
  import rlt_pkg::*;

  localparam int unsigned CAPACITY       = CAPACITY_DEF;
  localparam int unsigned CNT_W          = $clog2(CAPACITY) + 1;
  localparam logic        MODE_APPEND    = 1'b0;
  localparam logic        MODE_LOOKUP    = 1'b1;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PRINT_LIMIT    = 100;

  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] code;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  column;
    logic [POS_W-1:0]  position;
  } line_request_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  column;
  } line_answer_t;

  // Clock, reset and the request/result ports; every input starts known.
  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              start_i         = 1'b0;
  logic              busy_o;
  logic              mode_i          = MODE_APPEND;
  logic [BYTE_W-1:0] code_byte_i     = '0;
  logic [LINE_W-1:0] line_number_i   = '0;
  logic [COL_W-1:0]  column_number_i = '0;
  logic [POS_W-1:0]  position_i      = '0;
  logic              result_valid_o;
  logic [STAT_W-1:0] status_o;
  logic [LINE_W-1:0] found_line_o;
  logic [COL_W-1:0]  found_column_o;

  run_length_line_table_unit #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .code_byte_i    (code_byte_i),
    .line_number_i  (line_number_i),
    .column_number_i(column_number_i),
    .position_i     (position_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .found_line_o   (found_line_o),
    .found_column_o (found_column_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow line table. Keep the start offset of every run next to its length
  // so the search needs no prefix sums. Code bytes never come back out, so
  // they are not stored.
  // --------------------------------------------------------------------------
  logic [COL_W-1:0]  col_of_byte  [CAPACITY];
  logic [LINE_W-1:0] line_of_run  [CAPACITY];
  logic [CNT_W-1:0]  first_of_run [CAPACITY];
  logic [CNT_W-1:0]  len_of_run   [CAPACITY];
  logic [CNT_W-1:0]  byte_total = '0;
  logic [CNT_W-1:0]  run_total  = '0;

  line_request_t request_q [$];  // requests waiting to be driven
  line_answer_t  answer_q  [$];  // predicted results, oldest first
  int unsigned   err_count = 0;

  // Apply one accepted request to the shadow table and return its result.
  function automatic line_answer_t line_table_answer(line_request_t rq);
    line_answer_t ans;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    bit           hit;
    ans.status = STATUS_OK;
    ans.line   = '0;
    ans.column = '0;
    if (rq.mode == MODE_APPEND) begin
      if (byte_total >= CAPACITY) begin
        // Refuse: nothing stored, runs untouched.
        ans.status = STATUS_FULL;
      end else begin
        col_of_byte[byte_total] = rq.column;
        if (run_total != 0 && line_of_run[run_total-1] == rq.line) begin
          len_of_run[run_total-1] = len_of_run[run_total-1] + 1'b1;
        end else begin
          line_of_run[run_total]  = rq.line;
          first_of_run[run_total] = byte_total;
          len_of_run[run_total]   = CNT_W'(1);
          run_total               = run_total + 1'b1;
        end
        byte_total = byte_total + 1'b1;
      end
    end else begin
      hit = 1'b0;
      lo  = 0;
      hi  = 32'(run_total);
      if (rq.position < byte_total) begin
        // Bisect over the run start offsets, half-open interval [lo, hi).
        while (lo < hi && !hit) begin
          mid = (lo + hi) / 2;
          if (rq.position < first_of_run[mid]) begin
            hi = mid;
          end else if (rq.position >= first_of_run[mid] + len_of_run[mid]) begin
            lo = mid + 1;
          end else begin
            hit = 1'b1;
          end
        end
      end
      if (hit) begin
        ans.line   = line_of_run[mid];
        ans.column = col_of_byte[rq.position];
      end else begin
        ans.status = STATUS_NOT_FOUND;
      end
    end
    return ans;
  endfunction

  task automatic report_mismatch(input string what, input logic [LINE_W-1:0] got,
                                 input logic [LINE_W-1:0] want);
    if (err_count < PRINT_LIMIT)
      $display("%0t: MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
               want);
    err_count++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus generation. Track how many bytes the queued appends will have
  // stored so lookups can aim inside, at the edge of and past the range.
  // --------------------------------------------------------------------------
  int unsigned       gen_bytes = 0;
  logic [LINE_W-1:0] gen_last_line = '0;
  logic [LINE_W-1:0] gen_used_lines [$];

  task automatic queue_request(input logic mode, input logic [BYTE_W-1:0] code,
                               input logic [LINE_W-1:0] line,
                               input logic [COL_W-1:0] column,
                               input logic [POS_W-1:0] position);
    line_request_t rq;
    rq.mode     = mode;
    rq.code     = code;
    rq.line     = line;
    rq.column   = column;
    rq.position = position;
    request_q.push_back(rq);
    if (mode == MODE_APPEND && gen_bytes < CAPACITY) gen_bytes++;
  endtask

  // Pick a lookup position: mostly a stored byte, often the last stored one
  // or the first past the end, sometimes anywhere.
  function automatic logic [POS_W-1:0] pick_position();
    int unsigned sel;
    sel = $urandom_range(99);
    if (gen_bytes == 0 || sel >= 90) return POS_W'($urandom);
    if (sel < 70) return POS_W'($urandom_range(gen_bytes - 1, 0));
    if (sel < 80 || gen_bytes >= CAPACITY) return POS_W'(gen_bytes - 1);
    return POS_W'(gen_bytes);
  endfunction

  // Queue one line run: a series of appends that share a line number, with
  // columns mostly climbing as in real source text.
  task automatic queue_line_run();
    int unsigned       len;
    int unsigned       sel;
    int unsigned       k;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  column;
    sel = $urandom_range(99);
    if (sel < 60)      len = 1;
    else if (sel < 85) len = $urandom_range(8, 2);
    else               len = $urandom_range(40, 9);
    sel = $urandom_range(99);
    if (sel < 10)                                  line = gen_last_line;  // merges runs
    else if (sel < 20 && gen_used_lines.size() != 0)
      line = gen_used_lines[$urandom_range(gen_used_lines.size() - 1, 0)];
    else if (sel < 23)                             line = '0;
    else if (sel < 26)                             line = '1;
    else                                           line = LINE_W'($urandom);
    gen_last_line = line;
    gen_used_lines.push_back(line);
    column = COL_W'($urandom);
    for (k = 0; k < len; k++) begin
      queue_request(MODE_APPEND, BYTE_W'($urandom), line, column, POS_W'($urandom));
      column = ($urandom_range(3) == 0) ? COL_W'($urandom) : column + 1'b1;
    end
  endtask

  // Queue about n requests: line runs with append_pct percent odds, else a
  // short burst of lookups. Unused fields carry random noise.
  task automatic queue_mix(input int unsigned n, input int unsigned append_pct);
    int unsigned base;
    int unsigned k;
    int unsigned cnt;
    base = request_q.size();
    while (request_q.size() - base < n) begin
      if ($urandom_range(99) < append_pct) begin
        queue_line_run();
      end else begin
        cnt = $urandom_range(3, 1);
        for (k = 0; k < cnt; k++)
          queue_request(MODE_LOOKUP, BYTE_W'($urandom), LINE_W'($urandom),
                        COL_W'($urandom), pick_position());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: present one request at a time and hold it while busy_o is high.
  // Work in bursts of random length; drop start_i for a random gap between
  // bursts, and skip the gap now and then for back-to-back stretches.
  // --------------------------------------------------------------------------
  line_request_t req_on_port;
  int unsigned   gap_left   = 0;
  int unsigned   burst_left = 1;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin : drive
      line_request_t nxt;
      // The block took the request now on the ports: predict its result.
      if (start_i && !busy_o) answer_q.push_back(line_table_answer(req_on_port));
      if (!(start_i && busy_o)) begin
        if (gap_left != 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (request_q.size() != 0) begin
          nxt             = request_q.pop_front();
          req_on_port     = nxt;
          mode_i          <= nxt.mode;
          code_byte_i     <= nxt.code;
          line_number_i   <= nxt.line;
          column_number_i <= nxt.column;
          position_i      <= nxt.position;
          start_i         <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(40, 1);
            gap_left   = ($urandom_range(4) == 0) ? 0 : $urandom_range(8, 1);
          end
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: the block cannot be stalled, so take every strobe and compare
  // it with the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (rst_ni && result_valid_o) begin : check
      line_answer_t want;
      if (answer_q.size() == 0) begin
        report_mismatch("result with no request outstanding, status",
                        LINE_W'(status_o), '0);
      end else begin
        want = answer_q.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", LINE_W'(status_o), LINE_W'(want.status));
        if (found_line_o !== want.line)
          report_mismatch("found_line", found_line_o, want.line);
        if (found_column_o !== want.column)
          report_mismatch("found_column", found_column_o, want.column);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when neither a request nor a result moves for too
  // long, which also catches predictions that never get their result.
  // --------------------------------------------------------------------------
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    // Directed: lookups on the empty store, field extremes, a run that
    // grows, a new run, a return to an earlier line, hits at each byte,
    // a miss at the count and far past it. Unused fields get extremes.
    queue_request(MODE_LOOKUP, '1, '1, '1, '0);
    queue_request(MODE_LOOKUP, '0, '0, '0, '1);
    queue_request(MODE_APPEND, '0, '0, '0, '1);
    queue_request(MODE_APPEND, '1, '0, '1, '0);
    queue_request(MODE_APPEND, 8'hA5, '1, 16'h5A5A, '1);
    queue_request(MODE_APPEND, 8'h5A, '1, 16'h0001, 12'hA5A);
    queue_request(MODE_APPEND, 8'h3C, '0, 16'hA5A5, 12'h5A5);
    for (int unsigned p = 0; p < 5; p++)
      queue_request(MODE_LOOKUP, '1, '1, '1, POS_W'(p));
    queue_request(MODE_LOOKUP, '0, '0, '0, POS_W'(5));
    queue_request(MODE_LOOKUP, '1, '1, '1, '1);

    // Random: mixed traffic, then fill the store to capacity.
    queue_mix(2000, 60);
    while (gen_bytes < CAPACITY) queue_mix(20, 90);

    // Full store: refuse appends, hit at both ends and in the middle.
    queue_request(MODE_APPEND, '1, '1, '1, '1);
    queue_request(MODE_APPEND, '0, '0, '0, '0);
    queue_request(MODE_APPEND, '0, gen_last_line, '0, '0);
    queue_request(MODE_LOOKUP, '0, '0, '0, '0);
    queue_request(MODE_LOOKUP, '1, '1, '1, '1);
    queue_request(MODE_LOOKUP, '0, '0, '0, POS_W'(CAPACITY / 2));
    queue_mix(300, 50);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the last request to be taken and its result to come back,
    // then keep the clock running for DRAIN_CYCLES to catch stray strobes.
    while (request_q.size() != 0 || start_i) @(posedge clk_i);
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== run_length_line_table_unit.f =====
rtl/rlt_pkg.sv
rtl/rlt_ram.sv
rtl/run_length_line_table_unit.sv
tb/sv/run_length_line_table_unit_tb.sv
